/* sv/utf8_stream_decoder_macros.svh */
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Concurrent assertion shorthands shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define U8D_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("u8d assertion failed");

// Check that cons holds in the cycle after ante.
`define U8D_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("u8d assertion failed");

`else

`define U8D_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define U8D_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

/* sv/u8d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int unsigned CODE_W = 21;

	localparam logic [CODE_W-1:0] REPLACEMENT_CHAR = 21'h00FFFD;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_VALID     = 2'd0,
		STAT_MALFORMED = 2'd1,
		STAT_STOP      = 2'd2
	} status_t;

	// Range rule for the byte after a lead byte
	typedef enum logic [2:0] {
		RULE_NONE    = 3'd0,
		RULE_A0_BF   = 3'd1,
		RULE_LE_9F   = 3'd2,
		RULE_90_BF   = 3'd3,
		RULE_LE_8F   = 3'd4
	} rule_t;

	// Open sequence state
	typedef struct packed {
		logic [1:0]        pending;
		logic [CODE_W-1:0] partial;
		logic [2:0]        seq_len;
		logic              malformed;
		rule_t             rule;
	} state_t;

	// One result beat
	typedef struct packed {
		logic [CODE_W-1:0] code_point;
		logic [1:0]        status;
		logic [2:0]        bytes_used;
	} result_t;

	localparam state_t STATE_IDLE = '{
		pending:   2'd0,
		partial:   '0,
		seq_len:   3'd0,
		malformed: 1'b0,
		rule:      RULE_NONE
	};

endpackage
`default_nettype wire

/* sv/u8d_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_in_if
// Byte channel into the decoder: one text byte and the bytes left.
// ----------------------------------------------------------------------------
interface u8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic [2:0] bytes_left;

	modport source (output valid, output text_byte, output bytes_left, input ready);
	modport sink (input valid, input text_byte, input bytes_left, output ready);
endinterface
`default_nettype wire

/* sv/u8d_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_out_if
// Code point channel out of the decoder.
// ----------------------------------------------------------------------------
interface u8d_out_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [1:0]  status;
	logic [2:0]  bytes_used;

	modport source (output valid, output code_point, output status, output bytes_used,
		input ready);
	modport sink (input valid, input code_point, input status, input bytes_used,
		output ready);
endinterface
`default_nettype wire

/* sv/u8d_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_step
// Decode one byte against the open sequence state: next state and result.
// ----------------------------------------------------------------------------
module u8d_step (
	input  u8d_pkg::state_t  state,
	input  logic [7:0]       text_byte,
	input  logic [2:0]       bytes_left,
	output u8d_pkg::state_t  state_nxt,
	output logic             hit,
	output u8d_pkg::result_t result
);
	import u8d_pkg::*;

	logic [2:0]        need;
	logic              is_lead;
	logic [CODE_W-1:0] lead_bits;
	rule_t             lead_rule;
	logic              lead_bad;
	logic              rule_broken;
	logic              cont_bad;
	logic              mal_nxt;
	logic [1:0]        pend_nxt;
	logic [CODE_W-1:0] code_nxt;

	// Classify the lead byte
	always_comb begin
		need      = 3'd0;
		is_lead   = 1'b0;
		lead_bits = '0;
		if (text_byte[7:5] == 3'b110) begin
			need      = 3'd2;
			is_lead   = 1'b1;
			lead_bits = {10'd0, text_byte[4:0], 6'd0};
		end else if (text_byte[7:4] == 4'b1110) begin
			need      = 3'd3;
			is_lead   = 1'b1;
			lead_bits = {5'd0, text_byte[3:0], 12'd0};
		end else if (text_byte[7:3] == 5'b11110) begin
			need      = 3'd4;
			is_lead   = 1'b1;
			lead_bits = {text_byte[2:0], 18'd0};
		end
	end

	// Overlong and out-of-range leads, second byte rules
	assign lead_bad = ((need == 3'd2) && (text_byte < 8'hc2))
		|| ((need == 3'd4) && (text_byte > 8'hf4));

	always_comb begin
		case (text_byte)
			8'he0:   lead_rule = RULE_A0_BF;
			8'hed:   lead_rule = RULE_LE_9F;
			8'hf0:   lead_rule = RULE_90_BF;
			8'hf4:   lead_rule = RULE_LE_8F;
			default: lead_rule = RULE_NONE;
		endcase
	end

	// Check a continuation byte
	always_comb begin
		case (state.rule)
			RULE_A0_BF: rule_broken = (text_byte < 8'ha0) || (text_byte > 8'hbf);
			RULE_LE_9F: rule_broken = (text_byte > 8'h9f);
			RULE_90_BF: rule_broken = (text_byte < 8'h90) || (text_byte > 8'hbf);
			RULE_LE_8F: rule_broken = (text_byte > 8'h8f);
			default:    rule_broken = 1'b0;
		endcase
	end

	assign cont_bad = (text_byte[7:6] != 2'b10);
	assign mal_nxt  = state.malformed | rule_broken | cont_bad;
	assign pend_nxt = state.pending - 2'd1;

	// Merge six payload bits into their slot
	always_comb begin
		case (pend_nxt)
			2'd0:    code_nxt = state.partial | {15'd0, text_byte[5:0]};
			2'd1:    code_nxt = state.partial | {9'd0, text_byte[5:0], 6'd0};
			2'd2:    code_nxt = state.partial | {3'd0, text_byte[5:0], 12'd0};
			default: code_nxt = state.partial;
		endcase
	end

	// Next state and result
	always_comb begin
		state_nxt = state;
		hit       = 1'b0;
		result    = '{code_point: '0, status: STAT_VALID, bytes_used: 3'd1};
		if (state.pending == 2'd0) begin
			if (!text_byte[7]) begin
				hit               = 1'b1;
				result.code_point = {13'd0, text_byte};
				result.status     = (text_byte == 8'd0) ? STAT_STOP : STAT_VALID;
			end else if (!is_lead) begin
				hit           = 1'b1;
				result.status = STAT_STOP;
			end else if (bytes_left < need) begin
				hit               = 1'b1;
				result.code_point = REPLACEMENT_CHAR;
				result.status     = STAT_MALFORMED;
			end else begin
				state_nxt.seq_len   = need;
				state_nxt.pending   = need[1:0] - 2'd1;
				state_nxt.malformed = lead_bad;
				state_nxt.rule      = lead_rule;
				state_nxt.partial   = lead_bits;
			end
		end else if (pend_nxt != 2'd0) begin
			state_nxt.pending   = pend_nxt;
			state_nxt.partial   = code_nxt;
			state_nxt.malformed = mal_nxt;
			state_nxt.rule      = RULE_NONE;
		end else begin
			// Close the sequence; surrogates are malformed
			state_nxt         = STATE_IDLE;
			hit               = 1'b1;
			result.bytes_used = state.seq_len;
			if (mal_nxt || (code_nxt[20:11] == 10'h01b)) begin
				result.code_point = REPLACEMENT_CHAR;
				result.status     = STAT_MALFORMED;
			end else begin
				result.code_point = code_nxt;
				result.status     = STAT_VALID;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/utf8_stream_decoder.sv */
// A sequence's last byte is held in the input register; its result is then registered in the output register.
// Throughput: one byte per cycle while the output is not stalled; the input register refills while the result waits.
// The open-sequence state register closes the decode loop through the step logic.
// A stalled output holds the input side once both registers are full.
// Reset clears all valid flags and the sequence state; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_stream_decoder_macros.svh"
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-at-a-time UTF-8 decoder with validation, one code point per sequence.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  logic     clk,
	input  logic     arst_n,
	u8d_in_if.sink   text,
	u8d_out_if.source codes
);
	import u8d_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [2:0] left_s1;
	state_t     state_q;
	state_t     state_d;
	logic       hit;
	result_t    res_d;
	logic       res_valid_q;
	result_t    res_q;
	logic       out_free;
	logic       advance;

	// Step logic for the byte in the input register
	u8d_step u_step (
		.state      (state_q),
		.text_byte  (byte_s1),
		.bytes_left (left_s1),
		.state_nxt  (state_d),
		.hit        (hit),
		.result     (res_d)
	);

	// Advance when the byte makes no result or the output register frees up
	assign out_free   = !res_valid_q || codes.ready;
	assign advance    = valid_s1 && (!hit || out_free);
	assign text.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			left_s1 <= text.bytes_left;
		end
	end

	// Sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_IDLE;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= advance && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			res_q <= res_d;
		end
	end

	assign codes.valid      = res_valid_q;
	assign codes.code_point = res_q.code_point;
	assign codes.status     = res_q.status;
	assign codes.bytes_used = res_q.bytes_used;

	// Checks
	`U8D_ASSERT_IMPL(a_stop_shape, clk, arst_n,
		res_valid_q && (res_q.status == STAT_STOP),
		(res_q.code_point == '0) && (res_q.bytes_used == 3'd1))
	`U8D_ASSERT_IMPL(a_malformed_fffd, clk, arst_n,
		res_valid_q && (res_q.status == STAT_MALFORMED),
		res_q.code_point == REPLACEMENT_CHAR)
	`U8D_ASSERT_IMPL(a_open_len, clk, arst_n,
		state_q.pending != 2'd0,
		({1'b0, state_q.pending} < state_q.seq_len) && (state_q.seq_len >= 3'd2))
	`U8D_ASSERT_IMPL(a_idle_clean, clk, arst_n,
		state_q.pending == 2'd0,
		(state_q.partial == '0) && (state_q.rule == RULE_NONE) && !state_q.malformed)
	`U8D_ASSERT_NEXT(a_result_loaded, clk, arst_n,
		advance && hit,
		res_valid_q)

endmodule
`default_nettype wire

/* tb/utf8_decode_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_checker
// Watches the byte and code point channels of the UTF-8 stream decoder,
// predicts the code point for every accepted byte and compares each result
// beat, field by field, against the oldest predicted result.
// ----------------------------------------------------------------------------
module utf8_decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic [2:0]  in_left,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [20:0] out_code,
	input  logic [1:0]  out_status,
	input  logic [2:0]  out_used,
	output int          fail_count,
	output int          results_due
);
	import u8d_pkg::*;

	// Open sequence as the decoder should see it
	logic [1:0]  open_pending;
	logic [20:0] open_code;
	logic [2:0]  open_len;
	logic        open_bad;
	rule_t       open_rule;

	result_t expected_codes[$];

	function automatic void close_sequence();
		open_pending = 2'd0;
		open_code    = '0;
		open_len     = 3'd0;
		open_bad     = 1'b0;
		open_rule    = RULE_NONE;
	endfunction

	function automatic result_t make_result(logic [20:0] cp, status_t st, logic [2:0] used);
		result_t res;
		res.code_point = cp;
		res.status     = st;
		res.bytes_used = used;
		return res;
	endfunction

	// Advance the sequence state by one byte; return 1 when a code point is due
	function automatic bit predict_code_point(input logic [7:0] b, input logic [2:0] left,
		output result_t res);
		logic [2:0]  need;
		logic [20:0] bits;
		logic [20:0] cp;
		bit          bad;
		res  = '0;
		need = 3'd0;
		bits = '0;
		if (open_pending == 2'd0) begin
			if (b < 8'h80) begin
				res = make_result({13'd0, b}, (b == 8'h00) ? STAT_STOP : STAT_VALID, 3'd1);
				return 1'b1;
			end
			casez (b)
				8'b110?????: begin
					need = 3'd2;
					bits = {16'd0, b[4:0]};
				end
				8'b1110????: begin
					need = 3'd3;
					bits = {17'd0, b[3:0]};
				end
				8'b11110???: begin
					need = 3'd4;
					bits = {18'd0, b[2:0]};
				end
				default: begin
					res = make_result('0, STAT_STOP, 3'd1);
					return 1'b1;
				end
			endcase
			// too few bytes left: replace the lead byte alone
			if (left < need) begin
				res = make_result(REPLACEMENT_CHAR, STAT_MALFORMED, 3'd1);
				return 1'b1;
			end
			open_len     = need;
			open_pending = 2'(need - 3'd1);
			open_bad     = (need == 3'd2 && b < 8'hc2) || (need == 3'd4 && b > 8'hf4);
			case (b)
				8'he0:   open_rule = RULE_A0_BF;
				8'hed:   open_rule = RULE_LE_9F;
				8'hf0:   open_rule = RULE_90_BF;
				8'hf4:   open_rule = RULE_LE_8F;
				default: open_rule = RULE_NONE;
			endcase
			open_code = 21'(bits << (6 * (need - 3'd1)));
			return 1'b0;
		end

		// continuation slot: check the second byte range, then the 10xxxxxx form
		case (open_rule)
			RULE_A0_BF: if (b < 8'ha0 || b > 8'hbf) open_bad = 1'b1;
			RULE_LE_9F: if (b > 8'h9f) open_bad = 1'b1;
			RULE_90_BF: if (b < 8'h90 || b > 8'hbf) open_bad = 1'b1;
			RULE_LE_8F: if (b > 8'h8f) open_bad = 1'b1;
			default: ;
		endcase
		open_rule = RULE_NONE;
		if (b[7:6] != 2'b10)
			open_bad = 1'b1;
		open_pending = open_pending - 2'd1;
		open_code    = open_code | 21'({15'd0, b[5:0]} << (6 * open_pending));
		if (open_pending != 2'd0)
			return 1'b0;

		// last byte: surrogates are malformed too
		cp  = open_code;
		bad = open_bad || (cp[20:11] == 10'h01b);
		if (bad)
			res = make_result(REPLACEMENT_CHAR, STAT_MALFORMED, open_len);
		else
			res = make_result(cp, STAT_VALID, open_len);
		close_sequence();
		return 1'b1;
	endfunction

	// Compare result beats first, then predict from the byte beat of this edge
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			close_sequence();
			expected_codes.delete();
			fail_count  = 0;
			results_due <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_codes.size() == 0) begin
					$error("unexpected result: code_point %0h status %0d bytes_used %0d",
						out_code, out_status, out_used);
					fail_count++;
				end else begin
					want = expected_codes.pop_front();
					if (out_code !== want.code_point) begin
						$error("code_point mismatch: expected %0h, actual %0h",
							want.code_point, out_code);
						fail_count++;
					end
					if (out_status !== want.status) begin
						$error("status mismatch: expected %0d, actual %0d",
							want.status, out_status);
						fail_count++;
					end
					if (out_used !== want.bytes_used) begin
						$error("bytes_used mismatch: expected %0d, actual %0d",
							want.bytes_used, out_used);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (predict_code_point(in_byte, in_left, want))
					expected_codes.push_back(want);
			end
			results_due <= expected_codes.size();
		end
	end

endmodule

/* tb/tb_utf8_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder
// Drives the UTF-8 stream decoder with directed byte sequences and then with
// random texts, mostly well-formed with some corruption and raw noise, under
// random idling on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;

	logic clk;
	logic arst_n;

	u8d_in_if  text_ch();
	u8d_out_if code_ch();

	int fail_count;
	int results_due;

	bit         steady;
	bit         hold_req;
	bit         hold_done;
	int         sent_bytes;
	logic [7:0] text_bytes[$];

	utf8_stream_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.codes  (code_ch)
	);

	utf8_decode_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (text_ch.valid),
		.in_ready    (text_ch.ready),
		.in_byte     (text_ch.text_byte),
		.in_left     (text_ch.bytes_left),
		.out_valid   (code_ch.valid),
		.out_ready   (code_ch.ready),
		.out_code    (code_ch.code_point),
		.out_status  (code_ch.status),
		.out_used    (code_ch.bytes_used),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		#6_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Mostly short gaps, a few long ones, none in steady stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Offer one byte beat and hold it until accepted
	task automatic put_byte(input logic [7:0] b, input logic [2:0] left);
		int gap;
		text_ch.valid      <= 1'b1;
		text_ch.text_byte  <= b;
		text_ch.bytes_left <= left;
		do
			@(posedge clk);
		while (!text_ch.ready);
		sent_bytes++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Append one random character, encoded as UTF-8
	function automatic void append_char();
		logic [20:0] cp;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 40)
			cp = 21'($urandom_range(1, 'h7f));
		else if (r < 60)
			cp = 21'($urandom_range('h80, 'h7ff));
		else if (r < 80)
			cp = 21'($urandom_range('h800, 'hffff));
		else if (r < 95)
			cp = 21'($urandom_range('h10000, 'h10ffff));
		else begin
			case ($urandom_range(0, 7))
				0:       cp = 21'h80;
				1:       cp = 21'h7ff;
				2:       cp = 21'h800;
				3:       cp = 21'hffff;
				4:       cp = 21'h10000;
				5:       cp = 21'h10ffff;
				6:       cp = 21'hd7ff;
				default: cp = 21'hdfff;
			endcase
		end
		if (cp < 21'h80) begin
			text_bytes.push_back(cp[7:0]);
		end else if (cp < 21'h800) begin
			text_bytes.push_back({3'b110, cp[10:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			text_bytes.push_back({4'b1110, cp[15:12]});
			text_bytes.push_back({2'b10, cp[11:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end else begin
			text_bytes.push_back({5'b11110, cp[20:18]});
			text_bytes.push_back({2'b10, cp[17:12]});
			text_bytes.push_back({2'b10, cp[11:6]});
			text_bytes.push_back({2'b10, cp[5:0]});
		end
	endfunction

	// Build one text, maybe corrupt it, and send it with its bytes left
	task automatic send_text();
		int         n;
		int         k;
		int         pick;
		logic [2:0] left;
		text_bytes.delete();
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			n = $urandom_range(1, 8);
			repeat (n) text_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = $urandom_range(1, 10);
			repeat (n) append_char();
			if ($urandom_range(0, 4) == 0)
				text_bytes[$urandom_range(0, text_bytes.size() - 1)] =
					8'($urandom_range(0, 255));
			if ($urandom_range(0, 9) == 0 && text_bytes.size() > 1)
				text_bytes.delete($urandom_range(0, text_bytes.size() - 1));
			if ($urandom_range(0, 6) == 0)
				text_bytes.push_back(8'h00);
		end
		for (k = 0; k < text_bytes.size(); k++) begin
			left = (text_bytes.size() - k > 4) ? 3'd4 : 3'(text_bytes.size() - k);
			if (pick < 10 || $urandom_range(0, 15) == 0)
				left = 3'($urandom_range(0, 7));
			put_byte(text_bytes[k], left);
		end
	endtask

	// Receiver: random stalls and bursts, plus one long hold-off on request
	initial begin
		int r;
		int stall_left;
		int burst_left;
		stall_left    = 0;
		burst_left    = 0;
		code_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = 300;
				burst_left = 0;
			end
			if (stall_left > 0) begin
				code_ch.ready <= 1'b0;
				stall_left--;
			end else if (burst_left > 0) begin
				code_ch.ready <= 1'b1;
				burst_left--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					burst_left    = $urandom_range(50, 150);
					code_ch.ready <= 1'b1;
				end else if (r < 75) begin
					code_ch.ready <= 1'b1;
				end else begin
					stall_left    = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
					code_ch.ready <= 1'b0;
				end
			end
		end
	end

	// Sender and verdict
	initial begin
		text_ch.valid      = 1'b0;
		text_ch.text_byte  = 8'h00;
		text_ch.bytes_left = 3'd0;
		arst_n             = 1'b0;
		steady             = 1'b0;
		hold_req           = 1'b0;
		hold_done          = 1'b0;
		sent_bytes         = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// NUL, top of ASCII, lone continuation, F8..FF lead
		put_byte(8'h00, 3'd4);
		put_byte(8'h7f, 3'd7);
		put_byte(8'h80, 3'd4);
		put_byte(8'hff, 3'd1);
		// plain two-byte sequence, then an overlong lead
		put_byte(8'hc2, 3'd4);
		put_byte(8'ha9, 3'd3);
		put_byte(8'hc0, 3'd5);
		put_byte(8'h80, 3'd1);
		// second byte out of range after E0, surrogate after ED
		put_byte(8'he0, 3'd3);
		put_byte(8'h80, 3'd2);
		put_byte(8'hbf, 3'd1);
		put_byte(8'hed, 3'd4);
		put_byte(8'ha0, 3'd4);
		put_byte(8'h80, 3'd4);
		// highest code point, then a lead above F4
		put_byte(8'hf4, 3'd4);
		put_byte(8'h8f, 3'd3);
		put_byte(8'hbf, 3'd2);
		put_byte(8'hbf, 3'd1);
		put_byte(8'hf5, 3'd6);
		put_byte(8'h80, 3'd3);
		put_byte(8'h80, 3'd2);
		put_byte(8'h80, 3'd1);
		// too few bytes left for the lead
		put_byte(8'he2, 3'd2);
		put_byte(8'hf0, 3'd0);
		// NUL inside an open sequence
		put_byte(8'hc2, 3'd2);
		put_byte(8'h00, 3'd1);

		while (sent_bytes < 1600) begin
			steady = ($urandom_range(0, 7) == 0);
			// long receiver hold-off while bytes keep coming
			if (!hold_done && sent_bytes >= 600) begin
				hold_done = 1'b1;
				steady    = 1'b1;
				hold_req  = 1'b1;
				repeat (40) put_byte(8'($urandom_range(1, 127)), 3'd4);
				steady = 1'b0;
			end
			send_text();
		end

		text_ch.valid <= 1'b0;
		while (results_due != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (fail_count == 0 && results_due == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
